FILE: src/clt_pkg.sv
package clt_pkg;

  // Line geometry
  localparam int unsigned MAX_WORDS    = 8;
  localparam int unsigned MAX_WORD_LEN = 32;
  localparam int unsigned WIDX_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned POS_W        = $clog2(MAX_WORD_LEN + 1);

  // Result field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CPOS_W  = 5;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned SPACE_W = 9;

  // Control characters
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_KILL  = 8'h15;
  localparam logic [BYTE_W-1:0] CH_RDRAW = 8'h12;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0c;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;

  // Byte class decided by the front end
  typedef enum logic [2:0] {
    CLS_QUOTE,
    CLS_SPACE,
    CLS_ERASE,
    CLS_KILL,
    CLS_CLEAR,
    CLS_FF,
    CLS_CR,
    CLS_CHAR
  } clt_cls_e;

  // Action codes of a result
  typedef enum logic [2:0] {
    ACT_IGNORED  = 3'd0,
    ACT_ECHO     = 3'd1,
    ACT_STORED   = 3'd2,
    ACT_WORD_END = 3'd3,
    ACT_ERASED   = 3'd4,
    ACT_CLEARED  = 3'd5,
    ACT_DONE     = 3'd6,
    ACT_EMPTY    = 3'd7
  } clt_action_e;

  // Back end sequencer
  typedef enum logic {
    BK_IDLE,
    BK_SUM
  } clt_bk_state_e;

  // Classified byte travelling from front to back
  typedef struct packed {
    clt_cls_e          cls;
    logic [BYTE_W-1:0] data;
  } clt_item_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic      valid;
    clt_item_t item;
  } clt_q_t;

  // One result beat
  typedef struct packed {
    clt_action_e        action;
    logic [BYTE_W-1:0]  echo;
    logic [2:0]         widx;
    logic [CPOS_W-1:0]  cpos;
    logic [COUNT_W-1:0] count;
    logic [SPACE_W-1:0] spaces;
    logic               quoted;
  } clt_res_t;

  function automatic clt_cls_e clt_classify(logic [BYTE_W-1:0] b);
    clt_cls_e c;
    c = CLS_CHAR;
    if (b == CH_QUOTE)                  c = CLS_QUOTE;
    else if (b == CH_SPACE)             c = CLS_SPACE;
    else if (b == CH_BS || b == CH_DEL) c = CLS_ERASE;
    else if (b == CH_KILL)              c = CLS_KILL;
    else if (b == CH_RDRAW)             c = CLS_CLEAR;
    else if (b == CH_FF)                c = CLS_FF;
    else if (b == CH_CR)                c = CLS_CR;
    return c;
  endfunction

endpackage

FILE: src/clt_front.sv
module clt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte_i,
  output clt_pkg::clt_q_t    q_o,
  input  logic               q_pop_i
);
  import clt_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  clt_item_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]      cnt_q, cnt_d;
  logic                 wr_en, rd_en;

  assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign wr_en = push && !full;
  assign rd_en = q_pop_i && (cnt_q != '0);

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Classify on entry and store the beat
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= '{cls: clt_classify(in_byte_i), data: in_byte_i};
    end
  end

endmodule

FILE: src/clt_back.sv
module clt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clt_pkg::clt_q_t    q_i,
  output logic               q_pop_o,
  output clt_pkg::clt_res_t  res_o,
  output logic               res_valid_o,
  input  logic               res_pop_i
);
  import clt_pkg::*;

  clt_bk_state_e      state_q, state_d;
  logic               quote_q, quote_d;
  logic [WIDX_W-1:0]  word_q, word_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   len_q [MAX_WORDS];
  logic [POS_W-1:0]   len_d [MAX_WORDS];
  logic [WIDX_W-1:0]  k_q, k_d;
  logic [SPACE_W-1:0] sum_q, sum_d;
  clt_res_t           res_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic               start, produce, out_pop;
  logic [WIDX_W:0]    word_nxt;
  logic [SPACE_W-1:0] sum_add;

  assign out_pop  = res_pop_i && out_valid_q;
  assign start    = (state_q == BK_IDLE) && q_i.valid && (!out_valid_q || out_pop);
  assign q_pop_o  = start;
  assign word_nxt = {1'b0, word_q} + 1'b1;
  assign sum_add  = sum_q + SPACE_W'(len_q[k_q]) + SPACE_W'(2);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (start && q_i.item.cls == CLS_KILL) state_d = BK_SUM;
      BK_SUM:  if (k_q == word_q) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    quote_d = quote_q;
    word_d  = word_q;
    pos_d   = pos_q;
    len_d   = len_q;
    k_d     = k_q;
    sum_d   = sum_q;
    res_d   = '0;
    res_d.action = ACT_IGNORED;
    produce = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (start) begin
          produce = 1'b1;
          case (q_i.item.cls)
            CLS_QUOTE: begin
              quote_d      = ~quote_q;
              res_d.action = ACT_ECHO;
              res_d.echo   = q_i.item.data;
            end
            CLS_ERASE: res_d.action = ACT_IGNORED;
            CLS_KILL: begin
              produce = 1'b0;
              k_d     = '0;
              sum_d   = '0;
            end
            CLS_CLEAR: begin
              res_d.action = ACT_CLEARED;
              word_d       = '0;
              pos_d        = '0;
              len_d[0]     = '0;
            end
            CLS_FF: begin
              res_d.action = ACT_ECHO;
              res_d.echo   = q_i.item.data;
            end
            CLS_CR: begin
              if (word_q == '0 && pos_q == '0) begin
                res_d.action = ACT_EMPTY;
              end else begin
                res_d.action = ACT_DONE;
                res_d.count  = COUNT_W'(word_q) + COUNT_W'(pos_q != '0);
              end
              word_d = '0;
              pos_d  = '0;
            end
            default: begin
              // Space outside quotes splits words; all else is a character
              if (q_i.item.cls == CLS_SPACE && !quote_q) begin
                res_d.echo   = q_i.item.data;
                res_d.action = ACT_ECHO;
                if (pos_q != '0) begin
                  res_d.action = ACT_WORD_END;
                  pos_d        = '0;
                  if (word_nxt < (WIDX_W+1)'(MAX_WORDS)) begin
                    word_d         = word_nxt[WIDX_W-1:0];
                    len_d[word_d]  = '0;
                  end
                end
              end else if (pos_q < POS_W'(MAX_WORD_LEN)) begin
                res_d.action  = ACT_STORED;
                res_d.echo    = q_i.item.data;
                res_d.widx    = 3'(word_q);
                res_d.cpos    = CPOS_W'(pos_q);
                pos_d         = pos_q + 1'b1;
                len_d[word_q] = pos_d;
              end
            end
          endcase
        end
      end
      BK_SUM: begin
        // One stored length per cycle into the erase sum
        sum_d = sum_add;
        k_d   = k_q + 1'b1;
        if (k_q == word_q) begin
          produce      = 1'b1;
          res_d.action = ACT_ERASED;
          res_d.spaces = sum_add;
          word_d       = '0;
          pos_d        = '0;
          len_d[0]     = '0;
        end
      end
      default: ;
    endcase
    res_d.quoted = quote_d;
    out_valid_d  = produce ? 1'b1 : (out_pop ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      quote_q     <= 1'b0;
      word_q      <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_WORDS; i++) len_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      quote_q     <= quote_d;
      word_q      <= word_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      len_q       <= len_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (produce) res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = out_valid_q;

  // The erase walk only runs with the result slot free
  a_sum_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SUM) |-> !out_valid_q)
    else $error("erase walk with a result pending");

  // The walk never passes the current word
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SUM) |-> (k_q <= word_q))
    else $error("erase walk index past current word");

  // Write position stays within the word limit
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_WORD_LEN))
    else $error("write position beyond word limit");

  // Every byte other than a line erase yields a result in the next cycle
  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && q_i.item.cls != CLS_KILL) |=> out_valid_q)
    else $error("result missing after a byte");

endmodule

FILE: src/cli_line_tokenizer.sv
// Command-line tokenizer: splits received terminal bytes into words on spaces, with a
// double quote toggling a mode in which spaces are stored. Each byte pushed gives exactly
// one result beat, in order, carrying an action code and its fields. The front end
// classifies bytes into a two-beat queue; the back end holds the line state and a one-beat
// result register, so push may continue while a result waits to be popped. An ordinary
// byte's result is ready the cycle after it leaves the queue. A line erase (0x15) walks
// the stored word lengths one per cycle to form its erase space count.
module cli_line_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] action_o,
  output logic [7:0] echo_byte_o,
  output logic [2:0] word_index_o,
  output logic [4:0] char_position_o,
  output logic [3:0] word_count_o,
  output logic [8:0] erase_spaces_o,
  output logic       quoted_o
);
  import clt_pkg::*;

  clt_q_t   q;
  logic     q_pop;
  clt_res_t res;
  logic     res_valid;

  clt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_byte_i (in_byte_i),
    .q_o       (q),
    .q_pop_i   (q_pop)
  );

  clt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q),
    .q_pop_o     (q_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  // Result ports
  assign empty           = !res_valid;
  assign action_o        = res.action;
  assign echo_byte_o     = res.echo;
  assign word_index_o    = res.widx;
  assign char_position_o = res.cpos;
  assign word_count_o    = res.count;
  assign erase_spaces_o  = res.spaces;
  assign quoted_o        = res.quoted;

endmodule
